// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL files that check themselves.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked check, quiet while reset is applied.
`define SCAU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also evaluated during reset.
`define SCAU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/scau_pkg.sv
// ----------------------------------------------------------------------------
// Signed code arithmetic unit package
// Widths, opcodes and shared types of the signed code arithmetic unit.
// ----------------------------------------------------------------------------
package scau_pkg;

    localparam int WIDTH          = 16;
    localparam int FRACTION_BITS  = 5;
    localparam int MAG_W          = WIDTH - 1;
    localparam int HALF_W         = WIDTH / 2;
    localparam int QUOT_W         = MAG_W + FRACTION_BITS;
    localparam int DIV_STAGES     = 4;
    localparam int DIV_STEPS      = QUOT_W / DIV_STAGES;

    typedef enum logic [1:0] {
        OP_CONVERT  = 2'd0,
        OP_ADD      = 2'd1,
        OP_MULTIPLY = 2'd2,
        OP_DIVIDE   = 2'd3
    } t_opcode;

    // Partial remainder and dividend/quotient shift word of the divider.
    typedef struct packed {
        logic [MAG_W-1:0]  rem;
        logic [QUOT_W-1:0] dq;
    } t_div_state;

endpackage

// File: rtl/core/scau_div_stage.sv
// ----------------------------------------------------------------------------
// Divider stage
// Several restoring division steps followed by a pipeline register.
// ----------------------------------------------------------------------------
module scau_div_stage (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  scau_pkg::t_div_state  i_state,
    input  logic [scau_pkg::MAG_W-1:0] i_divisor,
    output scau_pkg::t_div_state  o_state
);
    import scau_pkg::*;

    t_div_state r_state;
    t_div_state n_state;

    always_comb begin
        logic [MAG_W:0] rem_sh;
        n_state = i_state;
        for (int s = 0; s < DIV_STEPS; s++) begin
            rem_sh = {n_state.rem, n_state.dq[QUOT_W-1]};
            if (rem_sh >= {1'b0, i_divisor}) begin
                rem_sh = rem_sh - {1'b0, i_divisor};
                n_state.dq = {n_state.dq[QUOT_W-2:0], 1'b1};
            end else begin
                n_state.dq = {n_state.dq[QUOT_W-2:0], 1'b0};
            end
            n_state.rem = rem_sh[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// File: rtl/core/signed_code_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// Signed code arithmetic unit
// Convert, add, multiply and divide on 16-bit signed numbers in three codes.
// ----------------------------------------------------------------------------
// The input channel takes one request (opcode and two operands) when i_valid
// and o_ready are both high. The result channel presents all result fields
// with o_valid and hands them over when i_ready is high as well.
// Every request yields exactly one result, in request order.
// There are six register stages: one splits the operands into sign and
// magnitude, one computes the code results and sets up the divider, and
// four stages each run five steps of the restoring divider. The first stage
// loads at the accepting edge, and the request then moves through the
// stages in order. The last divider stage is the output register.
// Throughput is one request per cycle unless stalled; the divider chain sets the depth.
// When the receiver stalls, the whole pipeline holds, and o_ready is low
// only while the output register is full and not being taken.
// A synchronous active-low reset clears all valid bits; payload registers
// are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_code_arithmetic_unit_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  scau_pkg::t_opcode          i_opcode,
    input  logic signed [15:0]         i_operand_a,
    input  logic signed [15:0]         i_operand_b,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [15:0]                o_direct_code,
    output logic [15:0]                o_ones_code,
    output logic [15:0]                o_twos_code,
    output logic                       o_quotient_sign,
    output logic [14:0]                o_quotient_whole,
    output logic [4:0]                 o_quotient_fraction,
    output logic                       o_overflow,
    output logic                       o_divide_by_zero
);
    import scau_pkg::*;

    // Fields that ride alongside the divider unchanged.
    typedef struct packed {
        logic              is_div;
        logic [WIDTH-1:0]  dir;
        logic [WIDTH-1:0]  one;
        logic [WIDTH-1:0]  two;
        logic              qs;
        logic              ovf;
        logic              dz;
        logic [MAG_W-1:0]  divisor;
    } t_carry;

    // The pipeline advances as a whole whenever the output can move on.
    logic advance;
    assign advance = !o_valid || i_ready;
    assign o_ready = advance;

    // ---------------- Stage 1: sign and magnitude split ----------------
    logic              r_s1_valid;
    t_opcode           r_s1_op;
    logic              r_s1_na, r_s1_nb;
    logic [MAG_W-1:0]  r_s1_ma, r_s1_mb;
    logic [WIDTH-1:0]  n_neg_a, n_neg_b;

    assign n_neg_a = -i_operand_a;
    assign n_neg_b = -i_operand_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_op <= i_opcode;
            r_s1_na <= i_operand_a[WIDTH-1];
            r_s1_nb <= i_operand_b[WIDTH-1];
            r_s1_ma <= i_operand_a[WIDTH-1] ? n_neg_a[MAG_W-1:0] : i_operand_a[MAG_W-1:0];
            r_s1_mb <= i_operand_b[WIDTH-1] ? n_neg_b[MAG_W-1:0] : i_operand_b[MAG_W-1:0];
        end
    end

    // ---------------- Stage 2: code results and divider setup ----------------
    function automatic logic [WIDTH-1:0] twos_of(input logic neg, input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] inv;
        inv = ~mag + 1'b1;
        return neg ? {1'b1, inv} : {1'b0, mag};
    endfunction

    t_carry            n_carry;
    t_div_state        n_div;

    always_comb begin
        logic [WIDTH-1:0] ta, tb, sum, prod;
        logic [MAG_W-1:0] low_m1;
        logic             pneg;
        n_carry         = '0;
        n_carry.divisor = r_s1_mb;
        n_div.rem       = '0;
        n_div.dq        = {r_s1_ma, {FRACTION_BITS{1'b0}}};
        ta   = twos_of(r_s1_na, r_s1_ma);
        tb   = twos_of(r_s1_nb, r_s1_mb);
        sum  = ta + tb;
        prod = {{(WIDTH-HALF_W){1'b0}}, r_s1_ma[HALF_W-1:0]}
             * {{(WIDTH-HALF_W){1'b0}}, r_s1_mb[HALF_W-1:0]};
        pneg = (r_s1_na != r_s1_nb) && (r_s1_ma != '0) && (r_s1_mb != '0);
        low_m1 = sum[MAG_W-1:0] - 1'b1;
        case (r_s1_op)
            OP_CONVERT: begin
                n_carry.dir = {r_s1_na, r_s1_ma};
                n_carry.one = r_s1_na ? {1'b1, ~r_s1_ma} : {1'b0, r_s1_ma};
                n_carry.two = ta;
            end
            OP_ADD: begin
                n_carry.two = sum;
                n_carry.ovf = (ta[WIDTH-1] == tb[WIDTH-1]) && (sum[WIDTH-1] != ta[WIDTH-1]);
                if (!sum[WIDTH-1]) begin
                    n_carry.dir = sum;
                    n_carry.one = sum;
                end else begin
                    // Negative sum: step back to ones' complement, then invert.
                    n_carry.one = {1'b1, low_m1};
                    n_carry.dir = {1'b1, ~low_m1};
                end
            end
            OP_MULTIPLY: begin
                n_carry.ovf = prod[WIDTH-1];
                n_carry.dir = {pneg, prod[MAG_W-1:0]};
                n_carry.one = pneg ? {1'b1, ~prod[MAG_W-1:0]} : {1'b0, prod[MAG_W-1:0]};
                n_carry.two = twos_of(pneg, prod[MAG_W-1:0]);
            end
            OP_DIVIDE: begin
                n_carry.is_div = 1'b1;
                n_carry.dz     = (r_s1_mb == '0);
                // A zero dividend gives an all-zero quotient with no sign.
                n_carry.qs     = (r_s1_mb != '0) && (r_s1_ma != '0) && (r_s1_na != r_s1_nb);
            end
            default: begin
                n_carry = '0;
            end
        endcase
    end

    // Index 0 is stage 2, indexes 1..DIV_STAGES follow each divider stage.
    logic       r_valid [0:DIV_STAGES];
    t_carry     r_carry [0:DIV_STAGES];
    t_div_state r_div0;
    t_div_state w_div   [1:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (advance) begin
            r_valid[0] <= r_s1_valid;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_carry[0] <= n_carry;
            r_div0     <= n_div;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_carry[k] <= r_carry[k-1];
            end
        end
    end

    // ---------------- Stages 3..6: restoring divider ----------------
    scau_div_stage u_div_first (
        .i_clk     (i_clk),
        .i_en      (advance),
        .i_state   (r_div0),
        .i_divisor (r_carry[0].divisor),
        .o_state   (w_div[1])
    );

    for (genvar g = 2; g <= DIV_STAGES; g++) begin : g_div
        scau_div_stage u_div (
            .i_clk     (i_clk),
            .i_en      (advance),
            .i_state   (w_div[g-1]),
            .i_divisor (r_carry[g-1].divisor),
            .o_state   (w_div[g])
        );
    end

    // ---------------- Outputs ----------------
    t_carry           w_out;
    logic             w_q_ok;
    assign w_out  = r_carry[DIV_STAGES];
    assign w_q_ok = w_out.is_div && !w_out.dz;

    assign o_valid             = r_valid[DIV_STAGES];
    assign o_direct_code       = w_out.dir;
    assign o_ones_code         = w_out.one;
    assign o_twos_code         = w_out.two;
    assign o_quotient_sign     = w_out.qs;
    assign o_quotient_whole    = w_q_ok ? w_div[DIV_STAGES].dq[QUOT_W-1:FRACTION_BITS] : '0;
    assign o_quotient_fraction = w_q_ok ? w_div[DIV_STAGES].dq[FRACTION_BITS-1:0] : '0;
    assign o_overflow          = w_out.ovf;
    assign o_divide_by_zero    = w_out.dz;

    // ---------------- Checks ----------------
    `SCAU_ASSERT(a_dz_clears_quotient, i_clk, i_rst_n,
        o_valid && o_divide_by_zero |-> o_quotient_whole == '0
            && o_quotient_fraction == '0 && !o_quotient_sign,
        "zero divisor left quotient bits set")
    `SCAU_ASSERT(a_flags_exclusive, i_clk, i_rst_n,
        o_valid |-> !(o_overflow && o_divide_by_zero), "overflow and divide by zero both raised")
    `SCAU_ASSERT(a_pipe_moves, i_clk, i_rst_n,
        r_valid[DIV_STAGES-1] && advance |=> o_valid, "request lost between last stages")
    `SCAU_ASSERT(a_stall_holds, i_clk, i_rst_n,
        r_s1_valid && !advance |=> r_s1_valid, "stalled first stage dropped its request")

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Signed code arithmetic unit testbench
// Drives convert, add, multiply and divide requests through the valid/ready
// input channel and checks every result against an in-bench predictor,
// in order, under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import scau_pkg::*;

typedef struct packed {
    logic [15:0] direct_code;
    logic [15:0] ones_code;
    logic [15:0] twos_code;
    logic        quotient_sign;
    logic [14:0] quotient_whole;
    logic [4:0]  quotient_fraction;
    logic        overflow;
    logic        divide_by_zero;
} t_code_result;

class code_scoreboard;
    t_code_result pending[$];
    int           errors;
    int           checked;

    // Sign and magnitude of a 16-bit two's complement operand; the magnitude
    // wraps to 15 bits, so the most negative value becomes a negative zero.
    static function void split(input logic [15:0] raw, output logic neg,
                               output logic [14:0] mag);
        logic [15:0] absval;
        neg = raw[15];
        absval = neg ? (16'h0000 - raw) : raw;
        mag = absval[14:0];
    endfunction

    static function void encode(input logic neg, input logic [14:0] mag,
                                output logic [15:0] dir, output logic [15:0] one,
                                output logic [15:0] two);
        logic [14:0] inv;
        inv = ~mag;
        if (!neg) begin
            dir = {1'b0, mag};
            one = {1'b0, mag};
            two = {1'b0, mag};
        end else begin
            dir = {1'b1, mag};
            one = {1'b1, inv};
            two = {1'b1, inv + 15'd1};
        end
    endfunction

    function t_code_result compute(t_opcode op, logic [15:0] a, logic [15:0] b);
        t_code_result r;
        logic        na, nb, pneg;
        logic [14:0] ma, mb, low_m1;
        logic [15:0] ta, tb, sum, d0, o0, prod;
        logic [19:0] frac;
        r = '0;
        split(a, na, ma);
        split(b, nb, mb);
        case (op)
            OP_CONVERT: begin
                encode(na, ma, r.direct_code, r.ones_code, r.twos_code);
            end
            OP_ADD: begin
                encode(na, ma, d0, o0, ta);
                encode(nb, mb, d0, o0, tb);
                sum = ta + tb;
                r.overflow = (ta[15] == tb[15]) && (sum[15] != ta[15]);
                r.twos_code = sum;
                if (!sum[15]) begin
                    r.direct_code = sum;
                    r.ones_code = sum;
                end else begin
                    low_m1 = sum[14:0] - 15'd1;
                    r.ones_code = {1'b1, low_m1};
                    r.direct_code = {1'b1, ~low_m1};
                end
            end
            OP_MULTIPLY: begin
                prod = ma[7:0] * mb[7:0];
                pneg = (na != nb) && (ma != 0) && (mb != 0);
                r.overflow = prod[15];
                encode(pneg, prod[14:0], r.direct_code, r.ones_code, r.twos_code);
            end
            default: begin
                if (mb == 0) begin
                    r.divide_by_zero = 1'b1;
                end else if (ma != 0) begin
                    r.quotient_sign = na ^ nb;
                    r.quotient_whole = ma / mb;
                    frac = {5'd0, ma % mb} << 5;
                    frac = frac / mb;
                    r.quotient_fraction = frac[4:0];
                end
            end
        endcase
        return r;
    endfunction

    function void note_request(t_opcode op, logic [15:0] a, logic [15:0] b);
        pending.insert(pending.size(), compute(op, a, b));
    endfunction

    function void check_result(t_code_result got);
        t_code_result want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got.direct_code !== want.direct_code)
            $display("%0t: direct_code exp %h act %h", $time, want.direct_code,
                     got.direct_code);
        if (got.ones_code !== want.ones_code)
            $display("%0t: ones_code exp %h act %h", $time, want.ones_code,
                     got.ones_code);
        if (got.twos_code !== want.twos_code)
            $display("%0t: twos_code exp %h act %h", $time, want.twos_code,
                     got.twos_code);
        if (got.quotient_sign !== want.quotient_sign)
            $display("%0t: quotient_sign exp %b act %b", $time, want.quotient_sign,
                     got.quotient_sign);
        if (got.quotient_whole !== want.quotient_whole)
            $display("%0t: quotient_whole exp %h act %h", $time, want.quotient_whole,
                     got.quotient_whole);
        if (got.quotient_fraction !== want.quotient_fraction)
            $display("%0t: quotient_fraction exp %h act %h", $time,
                     want.quotient_fraction, got.quotient_fraction);
        if (got.overflow !== want.overflow)
            $display("%0t: overflow exp %b act %b", $time, want.overflow, got.overflow);
        if (got.divide_by_zero !== want.divide_by_zero)
            $display("%0t: divide_by_zero exp %b act %b", $time, want.divide_by_zero,
                     got.divide_by_zero);
        if (got !== want) errors++;
    endfunction
endclass

module testbench;
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    t_opcode            opcode = OP_CONVERT;
    logic signed [15:0] operand_a = '0;
    logic signed [15:0] operand_b = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_code_result       got;
    int                 send_idle_pct = 34;
    int                 recv_idle_pct = 54;
    int                 requests_sent = 0;
    code_scoreboard     board;

    always #5 clk = ~clk;

    signed_code_arithmetic_unit_core uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_valid            (in_valid),
        .o_ready            (in_ready),
        .i_opcode           (opcode),
        .i_operand_a        (operand_a),
        .i_operand_b        (operand_b),
        .o_valid            (out_valid),
        .i_ready            (out_ready),
        .o_direct_code      (got.direct_code),
        .o_ones_code        (got.ones_code),
        .o_twos_code        (got.twos_code),
        .o_quotient_sign    (got.quotient_sign),
        .o_quotient_whole   (got.quotient_whole),
        .o_quotient_fraction(got.quotient_fraction),
        .o_overflow         (got.overflow),
        .o_divide_by_zero   (got.divide_by_zero)
    );

    // Receiver: random stalls, results checked at the accepting edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) board.check_result(got);
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Issues one request, with a random idle gap first, and holds it until
    // the unit takes it.
    task automatic send_request(t_opcode op, logic [15:0] a, logic [15:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_request(op, a, b);
        requests_sent++;
    endtask

    // Operand picks: one third random, the rest edge values and small
    // magnitudes so multiply stays in range and divide gets fractions.
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(5))
            0: return 16'(signed'($urandom_range(6)) - 3);
            1: return $urandom_range(1) ? 16'h7FFF : 16'h8001;
            2: return 16'(signed'($urandom_range(510)) - 255);
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_random(int count);
        repeat (count) begin
            send_request(t_opcode'($urandom_range(3)), pick_operand(), pick_operand());
        end
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, negative zero, wrap and overflow, divide corners.
        send_request(OP_CONVERT, 16'h0000, 16'h0000);
        send_request(OP_CONVERT, 16'h7FFF, 16'hFFFF);
        send_request(OP_CONVERT, 16'h8001, 16'h0000);
        send_request(OP_CONVERT, 16'h8000, 16'h0000);
        send_request(OP_CONVERT, 16'hFFFF, 16'h0000);
        send_request(OP_ADD, 16'h7FFF, 16'h0001);
        send_request(OP_ADD, 16'h8001, 16'hFFFF);
        send_request(OP_ADD, 16'h8000, 16'h8000);
        send_request(OP_ADD, 16'h0005, 16'hFFFB);
        send_request(OP_ADD, 16'hC000, 16'hC000);
        send_request(OP_MULTIPLY, 16'h00FF, 16'hFF01);
        send_request(OP_MULTIPLY, 16'h00B6, 16'h00B4);
        send_request(OP_MULTIPLY, 16'h0000, 16'hFFFD);
        send_request(OP_MULTIPLY, 16'h7FFF, 16'h8001);
        send_request(OP_DIVIDE, 16'h0007, 16'h0000);
        send_request(OP_DIVIDE, 16'h0000, 16'h0000);
        send_request(OP_DIVIDE, 16'h0000, 16'hFFFD);
        send_request(OP_DIVIDE, 16'h7FFF, 16'h0001);
        send_request(OP_DIVIDE, 16'h8001, 16'h0003);
        send_request(OP_DIVIDE, 16'h0001, 16'h7FFF);
        send_request(OP_DIVIDE, 16'hFFF9, 16'hFFFE);
        send_request(OP_DIVIDE, 16'h0005, 16'h8000);

        run_random(130);
        send_idle_pct = 54;
        recv_idle_pct = 34;
        run_random(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(130);
        in_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d requests over all four operations; %0d results checked.",
                 requests_sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("** signed_code_arithmetic_unit_core: PASSED **");
        end else begin
            $display("** signed_code_arithmetic_unit_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout waiting for the unit.");
        $display("** signed_code_arithmetic_unit_core: FAILED **");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/scau_pkg.sv
rtl/core/scau_div_stage.sv
rtl/core/signed_code_arithmetic_unit_core.sv
dv/testbench.sv
